// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is asserted.
`define CSE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check on every rising edge, reset included.
`define CSE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/cse_pkg.sv =====
`timescale 1ns / 1ps

package cse_pkg;

  localparam int unsigned ValW = 16;

  localparam logic [ValW-1:0] HI_V_MIN_MV = 16'd3300;
  localparam logic [ValW-1:0] HI_V_MAX_MV = 16'd48000;
  localparam logic [ValW-1:0] LO_V_MIN_MV = 16'd1000;
  localparam logic [ValW-1:0] LO_V_MAX_MV = 16'd24000;

  localparam logic [15:0] DIV10_RECIP = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam logic [17:0] SLOPE_UNITY = 18'sd65536;

  typedef enum logic [2:0] {
    REG_HV_RANGE   = 3'd0,
    REG_VOLT_SLOPE = 3'd1,
    REG_VOLT_OFS   = 3'd2,
    REG_CURR_SLOPE = 3'd3,
    REG_CURR_OFS   = 3'd4,
    REG_EXT_LIMIT  = 3'd5,
    REG_CURR_MIN   = 3'd6,
    REG_CURR_MAX   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [ValW-1:0] lo;
    logic [ValW-1:0] hi;
  } limits_t;

endpackage

// ===== rtl/calibrated_setpoint_encoder_unit.sv =====
`timescale 1ns / 1ps
// A request moves through the stage 1, 2 and 3 registers into the output register.
// Throughput: one request per cycle unless the output stalls; the clamp, the
// calibration multiply, the offset add with re-clamp and the step division each take one pipeline stage.
// Reset: asynchronous active low; empties the pipeline and loads the register
// defaults (high range, unity slopes, zero offsets, current limits 0..65535 mA).
module calibrated_setpoint_encoder_unit
  import cse_pkg::*;
#(
  parameter int unsigned CURRENT_STEP_MA = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] request_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] clamped_request_o,
  output logic [15:0] calibrated_value_o,
  output logic [3:0]  code_high_o,
  output logic [7:0]  code_low_o,
  output logic        code_present_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CurLog   = $clog2(CURRENT_STEP_MA);
  localparam int unsigned CurShift = 16 + CurLog;
  localparam int unsigned RecipW   = 18;
  localparam int unsigned ProdW    = CurShift + RecipW;
  localparam logic [RecipW-1:0] CurRecip =
    RecipW'(((64'd1 << CurShift) + 64'(CURRENT_STEP_MA) - 64'd1) / 64'(CURRENT_STEP_MA));

  // configuration registers
  logic               hv_range_q;
  logic signed [17:0] volt_slope_q;
  logic signed [20:0] volt_ofs_q;
  logic signed [17:0] curr_slope_q;
  logic signed [20:0] curr_ofs_q;
  logic               ext_limit_q;
  logic [15:0]        curr_min_q;
  logic [15:0]        curr_max_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_range_q   <= 1'b1;
      volt_slope_q <= SLOPE_UNITY;
      volt_ofs_q   <= '0;
      curr_slope_q <= SLOPE_UNITY;
      curr_ofs_q   <= '0;
      ext_limit_q  <= 1'b0;
      curr_min_q   <= '0;
      curr_max_q   <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HV_RANGE:   hv_range_q   <= pwdata[0];
        REG_VOLT_SLOPE: volt_slope_q <= pwdata[17:0];
        REG_VOLT_OFS:   volt_ofs_q   <= pwdata[20:0];
        REG_CURR_SLOPE: curr_slope_q <= pwdata[17:0];
        REG_CURR_OFS:   curr_ofs_q   <= pwdata[20:0];
        REG_EXT_LIMIT:  ext_limit_q  <= pwdata[0];
        REG_CURR_MIN:   curr_min_q   <= pwdata[15:0];
        REG_CURR_MAX:   curr_max_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HV_RANGE:   prdata = {31'd0, hv_range_q};
      REG_VOLT_SLOPE: prdata = {{14{volt_slope_q[17]}}, volt_slope_q};
      REG_VOLT_OFS:   prdata = {{11{volt_ofs_q[20]}}, volt_ofs_q};
      REG_CURR_SLOPE: prdata = {{14{curr_slope_q[17]}}, curr_slope_q};
      REG_CURR_OFS:   prdata = {{11{curr_ofs_q[20]}}, curr_ofs_q};
      REG_EXT_LIMIT:  prdata = {31'd0, ext_limit_q};
      REG_CURR_MIN:   prdata = {16'd0, curr_min_q};
      REG_CURR_MAX:   prdata = {16'd0, curr_max_q};
      default:        prdata = '0;
    endcase
  end

  // pipeline flow control
  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en     = !out_valid_q || out_ready_i;
  assign s3_en      = !s3_valid_q || out_en;
  assign s2_en      = !s2_valid_q || s3_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_q  <= in_valid_i;
      if (s2_en)  s2_valid_q  <= s1_valid_q;
      if (s3_en)  s3_valid_q  <= s2_valid_q;
      if (out_en) out_valid_q <= s3_valid_q;
    end
  end

  limits_t volt_lim;
  limits_t curr_lim;

  always_comb begin
    volt_lim.lo = hv_range_q ? HI_V_MIN_MV : LO_V_MIN_MV;
    volt_lim.hi = hv_range_q ? HI_V_MAX_MV : LO_V_MAX_MV;
    curr_lim.lo = curr_min_q;
    curr_lim.hi = curr_max_q;
  end

  // stage 1: range clamp
  logic        s1_mode_q;
  logic [15:0] s1_clamp_q;
  logic [15:0] s1_clamp_d;
  limits_t     in_lim;

  always_comb begin
    in_lim = mode_i ? curr_lim : volt_lim;
    if (request_value_i > in_lim.hi) begin
      s1_clamp_d = in_lim.hi;
    end else if (request_value_i < in_lim.lo) begin
      s1_clamp_d = in_lim.lo;
    end else begin
      s1_clamp_d = request_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_mode_q  <= mode_i;
      s1_clamp_q <= s1_clamp_d;
    end
  end

  // stage 2: slope multiply
  logic               s2_mode_q;
  logic [15:0]        s2_clamp_q;
  logic signed [34:0] s2_prod_q;
  logic signed [34:0] s2_prod_d;
  logic signed [17:0] slope_sel;

  always_comb begin
    slope_sel = s1_mode_q ? curr_slope_q : volt_slope_q;
    s2_prod_d = $signed({1'b0, s1_clamp_q}) * slope_sel;
  end

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_mode_q  <= s1_mode_q;
      s2_clamp_q <= s1_clamp_q;
      s2_prod_q  <= s2_prod_d;
    end
  end

  // stage 3: offset add and re-clamp
  logic               s3_mode_q;
  logic [15:0]        s3_clamp_q;
  logic [15:0]        s3_cal_q;
  logic [15:0]        s3_cal_d;
  logic signed [20:0] ofs_sel;
  logic signed [35:0] sum;
  logic signed [35:0] lo_fix;
  logic signed [35:0] hi_fix;
  limits_t            cal_lim;

  always_comb begin
    ofs_sel = s2_mode_q ? curr_ofs_q : volt_ofs_q;
    cal_lim = s2_mode_q ? curr_lim : volt_lim;
    sum     = $signed({s2_prod_q[34], s2_prod_q})
            + $signed({{3{ofs_sel[20]}}, ofs_sel, 12'd0});
    lo_fix  = $signed({4'd0, cal_lim.lo, 16'd0});
    hi_fix  = $signed({4'd0, cal_lim.hi, 16'd0});
    if (sum <= lo_fix) begin
      s3_cal_d = cal_lim.lo;
    end else if (sum >= hi_fix) begin
      s3_cal_d = cal_lim.hi;
    end else begin
      s3_cal_d = sum[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_mode_q  <= s2_mode_q;
      s3_clamp_q <= s2_clamp_q;
      s3_cal_q   <= s3_cal_d;
    end
  end

  // stage 4: step division and code packing
  logic [31:0]      volt_prod;
  logic [12:0]      volt_q10;
  logic [11:0]      volt_code;
  logic [ProdW-1:0] curr_prod;
  logic [7:0]       curr_code;
  logic [3:0]       code_high_d;
  logic [7:0]       code_low_d;
  logic             code_present_d;

  logic [15:0] clamped_q;
  logic [15:0] cal_q;
  logic [3:0]  code_high_q;
  logic [7:0]  code_low_q;
  logic        code_present_q;

  always_comb begin
    volt_prod = 32'(s3_cal_q) * 32'(DIV10_RECIP);
    volt_q10  = volt_prod[DIV10_SHIFT +: 13];
    volt_code = hv_range_q ? volt_q10[12:1] : volt_q10[11:0];
    curr_prod = ProdW'(s3_cal_q) * ProdW'(CurRecip);
    curr_code = curr_prod[CurShift +: 8];
    if (!s3_mode_q) begin
      code_high_d    = volt_code[11:8];
      code_low_d     = volt_code[7:0];
      code_present_d = 1'b1;
    end else if (!ext_limit_q) begin
      code_high_d    = '0;
      code_low_d     = curr_code;
      code_present_d = 1'b1;
    end else begin
      code_high_d    = '0;
      code_low_d     = '0;
      code_present_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      clamped_q      <= s3_clamp_q;
      cal_q          <= s3_cal_q;
      code_high_q    <= code_high_d;
      code_low_q     <= code_low_d;
      code_present_q <= code_present_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign clamped_request_o  = clamped_q;
  assign calibrated_value_o = cal_q;
  assign code_high_o        = code_high_q;
  assign code_low_o         = code_low_q;
  assign code_present_o     = code_present_q;

endmodule

// ===== rtl/cse_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cse_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] calibrated_value_o,
  input logic [3:0]  code_high_o,
  input logic [7:0]  code_low_o,
  input logic        code_present_o
);

  logic out_stall;
  logic no_code;
  logic code_clear;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign no_code    = out_valid_o && !code_present_o;
  assign code_clear = (code_high_o == 4'd0) && (code_low_o == 8'd0);

  `CSE_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> out_valid_o && $stable(calibrated_value_o))
  `CSE_ASSERT(a_no_code_zero, clk_i, rst_ni, no_code |-> code_clear)
  `CSE_ASSERT(a_code_high_range, clk_i, rst_ni, out_valid_o |-> code_high_o <= 4'd9)
  `CSE_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind calibrated_setpoint_encoder_unit cse_checker u_cse_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .calibrated_value_o (calibrated_value_o),
  .code_high_o        (code_high_o),
  .code_low_o         (code_low_o),
  .code_present_o     (code_present_o)
);
